// ----- src/ddh_pkg.sv -----
// ----------------------------------------------------------------------------
// Delay-Doppler histogram package
// Shared types and constants for the histogram front end and binning engine.
// ----------------------------------------------------------------------------
package ddh_pkg;

	localparam int MaxPixels = 65536;
	localparam int MaxDim    = 256;
	localparam int PixAw     = $clog2(MaxPixels);
	localparam int PixCntW   = PixAw + 1;
	localparam int BinAw     = $clog2(MaxDim * MaxDim);
	localparam int DimW      = $clog2(MaxDim) + 1;
	localparam int QDepth    = 4;
	localparam int QAw       = $clog2(QDepth);

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_COMPUTE = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_COMPUTE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] vel;
		logic [15:0] wgt;
		logic [15:0] dep;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_BIN,
		ST_DRAIN,
		ST_STATUS,
		ST_READ,
		ST_OUT
	} eng_state_t;

	typedef enum logic [2:0] {
		PH_FETCH,
		PH_START,
		PH_WAIT,
		PH_RDBIN,
		PH_WRITE
	} bin_ph_t;

	function automatic logic [DimW-1:0] dim_sat(input logic [8:0] r);
		logic [DimW-1:0] res;
		if (r == 9'd0) begin
			res = DimW'(1);
		end else if (32'(r) > MaxDim) begin
			res = DimW'(MaxDim);
		end else begin
			res = DimW'(r);
		end
		return res;
	endfunction

endpackage

// ----- src/delay_doppler_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// Delay-Doppler histogram unit
// Weighted two-dimensional velocity/depth histogram with min/max binning.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (in_valid/in_stall): a load stores a
// pixel, a compute bins all stored pixels, a read returns the next bin.
// Results leave on the output channel (out_valid/out_stall) from a single
// output register. Configuration writes (cfg_valid/cfg_ready) set the image
// width and height and are taken only while the block is idle.
// A queue of four commands separates the front end from the engine.
// A load is stored while the engine stays idle. A read fetches its bin in the
// read state and loads it into the output register in the out state.
// A compute first clears 65536 bins, one a cycle, then passes each valid
// pixel through the bit-serial bin index dividers, then gives one status result.
// When the receiver stalls, the output register holds its result and the
// engine waits; the queue then fills and the input stalls.
// Reset empties the pixel store and the queue and restores the statistics
// and the 64 by 64 image size; reads before the first compute return zeros.
// ----------------------------------------------------------------------------
module delay_doppler_histogram_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] radial_velocity,
	input  logic [15:0] scattering,
	input  logic [15:0] depth,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] bin_value,
	output logic        bin_last,
	output logic [16:0] pixels_binned,
	output logic        is_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);
	logic [8:0]    width_q, height_q;
	logic          cmd_valid, cmd_take, q_empty, eng_busy;
	ddh_pkg::cmd_t cmd;

	assign cfg_ready = q_empty && !eng_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd64;
			height_q <= 9'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ddh_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				ddh_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ddh_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .radial_velocity(radial_velocity), .scattering(scattering),
		.depth(depth), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.empty(q_empty)
	);

	ddh_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .w(ddh_pkg::dim_sat(width_q)), .h(ddh_pkg::dim_sat(height_q)),
		.out_valid(out_valid), .out_stall(out_stall), .bin_value(bin_value),
		.bin_last(bin_last), .pixels_binned(pixels_binned), .is_status(is_status),
		.busy(eng_busy)
	);

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken with no command waiting");
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_status) |-> (bin_value == 32'd0 && !bin_last))
		else $error("status result carries bin data");
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_status) |-> (pixels_binned == 17'd0))
		else $error("bin readout carries a pixel count");
	a_empty_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !cmd_take)
		else $error("command taken from empty queue");

endmodule

// ----- src/ddh_divider.sv -----
// ----------------------------------------------------------------------------
// Delay-Doppler histogram bin index divider
// Restoring divider, one quotient bit a cycle: q = floor(n * off / range).
// ----------------------------------------------------------------------------
module ddh_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ddh_pkg::DimW-1:0]      n,
	input  logic [16:0]                   off,
	input  logic [16:0]                   range,
	output logic                          done,
	output logic [ddh_pkg::DimW-1:0]      quo
);
	localparam int NumW = ddh_pkg::DimW + 17;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] num_q;
	logic [17:0]     rem_q;
	logic [16:0]     den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            zero_q;
	logic [17:0]     rem_sh;
	logic [17:0]     rem_sub;

	assign rem_sh  = {rem_q[16:0], num_q[NumW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				if (cnt_q == CntW'(1) || zero_q) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= NumW'(n) * NumW'(off);
			rem_q  <= '0;
			den_q  <= range;
			zero_q <= (range == 17'd0);
		end else if (busy_q && !zero_q) begin
			if (!rem_sub[17]) begin
				rem_q <= rem_sub;
				num_q <= {num_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[NumW-2:0], 1'b0};
			end
		end else if (busy_q && zero_q) begin
			num_q <= '0;
		end
	end

	assign quo = ddh_pkg::DimW'(num_q);

endmodule

// ----- src/ddh_front.sv -----
// ----------------------------------------------------------------------------
// Delay-Doppler histogram front end
// Accepts items, classifies them and queues commands for the engine.
// ----------------------------------------------------------------------------
module ddh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           kind,
	input  logic [15:0]          radial_velocity,
	input  logic [15:0]          scattering,
	input  logic [15:0]          depth,
	output logic                 cmd_valid,
	input  logic                 cmd_take,
	output ddh_pkg::cmd_t        cmd,
	output logic                 empty
);
	localparam int QA = ddh_pkg::QAw;

	ddh_pkg::cmd_t  q_mem [ddh_pkg::QDepth];
	logic [QA-1:0]  wr_q;
	logic [QA-1:0]  rd_q;
	logic [QA:0]    cnt_q;
	logic           push;
	logic           pop;
	logic           known;
	ddh_pkg::cmd_t  new_cmd;

	assign in_stall = (cnt_q == (QA+1)'(ddh_pkg::QDepth));
	assign known    = (kind == ddh_pkg::KIND_LOAD) || (kind == ddh_pkg::KIND_COMPUTE)
	                  || (kind == ddh_pkg::KIND_READ);
	assign push     = in_valid && !in_stall && known;
	assign pop      = cmd_valid && cmd_take;
	assign cmd_valid = (cnt_q != '0);
	assign cmd      = q_mem[rd_q];
	assign empty    = (cnt_q == '0);

	always_comb begin
		new_cmd.vel = radial_velocity;
		new_cmd.wgt = scattering;
		new_cmd.dep = depth;
		case (kind)
			ddh_pkg::KIND_LOAD:    new_cmd.op = ddh_pkg::OP_LOAD;
			ddh_pkg::KIND_COMPUTE: new_cmd.op = ddh_pkg::OP_COMPUTE;
			default:               new_cmd.op = ddh_pkg::OP_READ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QA'(1);
			if (pop)  rd_q <= rd_q + QA'(1);
			cnt_q <= cnt_q + (QA+1)'(push) - (QA+1)'(pop);
		end
	end

endmodule

// ----- src/ddh_engine.sv -----
// ----------------------------------------------------------------------------
// Delay-Doppler histogram engine
// Stores pixels, keeps statistics, bins the image and reads out bins.
// ----------------------------------------------------------------------------
module ddh_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_take,
	input  ddh_pkg::cmd_t             cmd,
	input  logic [ddh_pkg::DimW-1:0]  w,
	input  logic [ddh_pkg::DimW-1:0]  h,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [31:0]               bin_value,
	output logic                      bin_last,
	output logic [16:0]               pixels_binned,
	output logic                      is_status,
	output logic                      busy
);
	localparam int PA = ddh_pkg::PixAw;
	localparam int PC = ddh_pkg::PixCntW;
	localparam int BA = ddh_pkg::BinAw;
	localparam int DW = ddh_pkg::DimW;
	localparam int BC = BA + 1;

	logic [15:0] vel_mem [ddh_pkg::MaxPixels];
	logic [15:0] wgt_mem [ddh_pkg::MaxPixels];
	logic [15:0] dep_mem [ddh_pkg::MaxPixels];
	logic [31:0] img_mem [ddh_pkg::MaxDim * ddh_pkg::MaxDim];

	ddh_pkg::eng_state_t st_q, st_d;

	logic [PC-1:0]  pcount_q;
	logic signed [15:0] vmin_q, vmax_q;
	logic [15:0]    dmin_q, dmax_q;
	logic [BC-1:0]  rptr_q;
	logic [16:0]    binned_q;
	logic [BC-1:0]  clr_q;
	logic [PC-1:0]  pix_q;
	logic           computed_q;

	// Binning sub-sequence: fetch, start dividers, wait, read bin, write bin.
	ddh_pkg::bin_ph_t ph_q;
	logic signed [15:0] pv_q;
	logic [15:0]    pw_q, pd_q;
	logic [DW-1:0]  col_q, row_q;
	logic           cdone_q, rdone_q;
	logic [BA-1:0]  bidx_q;
	logic [31:0]    img_rd_q;
	logic [16:0]    vrange, drange, voff, doff;
	logic           div_start;
	logic           div_go;
	logic           cdone, rdone;
	logic [DW-1:0]  cquo, rquo;
	logic [BC-1:0]  total;
	logic [32:0]    sum;
	logic           out_free;
	logic           out_load;
	logic [31:0]    ob_val_q;
	logic           ob_last_q, ob_stat_q;
	logic [16:0]    ob_bin_q;
	logic           pix_ok;

	assign total  = BC'(w) * BC'(h);
	assign vrange = (vmax_q >= vmin_q) ? 17'($signed(17'(signed'(vmax_q))) -
	                $signed(17'(signed'(vmin_q)))) : 17'd0;
	assign drange = (dmax_q >= dmin_q) ? {1'b0, dmax_q - dmin_q} : 17'd0;
	assign voff   = 17'($signed(17'(signed'(pv_q))) - $signed(17'(signed'(vmin_q))));
	assign doff   = {1'b0, pd_q - dmin_q};
	assign div_start = (st_q == ddh_pkg::ST_BIN) && (ph_q == ddh_pkg::PH_START);
	assign pix_ok = (pd_q != 16'd0) && (pv_q >= vmin_q) && (pd_q >= dmin_q);
	assign div_go = div_start && pix_ok;

	ddh_divider u_cdiv (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(w), .off(voff),
		.range(vrange), .done(cdone), .quo(cquo)
	);
	ddh_divider u_rdiv (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(h), .off(doff),
		.range(drange), .done(rdone), .quo(rquo)
	);

	assign out_free = !out_valid || !out_stall;
	assign out_load = out_free && (st_q == ddh_pkg::ST_STATUS || st_q == ddh_pkg::ST_OUT);
	assign sum      = {1'b0, img_rd_q} + {17'd0, pw_q};
	assign busy     = (st_q != ddh_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ddh_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		cmd_take = 1'b0;
		case (st_q)
			ddh_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					case (cmd.op)
						ddh_pkg::OP_COMPUTE: st_d = ddh_pkg::ST_CLEAR;
						ddh_pkg::OP_READ:    st_d = ddh_pkg::ST_READ;
						default:             st_d = ddh_pkg::ST_IDLE;
					endcase
				end
			end
			ddh_pkg::ST_CLEAR: begin
				if (clr_q == BC'(ddh_pkg::MaxDim * ddh_pkg::MaxDim - 1)) begin
					st_d = ddh_pkg::ST_BIN;
				end
			end
			ddh_pkg::ST_BIN: begin
				if (ph_q == ddh_pkg::PH_FETCH && pix_q == pcount_q) begin
					st_d = ddh_pkg::ST_STATUS;
				end
			end
			ddh_pkg::ST_STATUS: begin
				if (out_free) st_d = ddh_pkg::ST_IDLE;
			end
			ddh_pkg::ST_READ: st_d = ddh_pkg::ST_OUT;
			ddh_pkg::ST_OUT: begin
				if (out_free) st_d = ddh_pkg::ST_IDLE;
			end
			default: st_d = ddh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ddh_pkg::ST_IDLE && cmd_valid && cmd.op == ddh_pkg::OP_LOAD
		    && pcount_q < PC'(ddh_pkg::MaxPixels)) begin
			vel_mem[PA'(pcount_q)] <= cmd.vel;
			wgt_mem[PA'(pcount_q)] <= cmd.wgt;
			dep_mem[PA'(pcount_q)] <= cmd.dep;
		end
		if (st_q == ddh_pkg::ST_BIN && ph_q == ddh_pkg::PH_FETCH) begin
			pv_q <= vel_mem[PA'(pix_q)];
			pw_q <= wgt_mem[PA'(pix_q)];
			pd_q <= dep_mem[PA'(pix_q)];
		end
		if (st_q == ddh_pkg::ST_CLEAR) begin
			img_mem[BA'(clr_q)] <= 32'd0;
		end else if (st_q == ddh_pkg::ST_BIN && ph_q == ddh_pkg::PH_WRITE) begin
			img_mem[bidx_q] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
		if (st_q == ddh_pkg::ST_BIN && ph_q == ddh_pkg::PH_RDBIN) begin
			img_rd_q <= img_mem[bidx_q];
		end else if (st_q == ddh_pkg::ST_READ) begin
			img_rd_q <= img_mem[(rptr_q >= total) ? BA'(0) : BA'(rptr_q)];
		end
		if (cdone) col_q <= cquo;
		if (rdone) row_q <= rquo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q   <= '0;
			vmin_q     <= 16'sh7FFF;
			vmax_q     <= 16'sh8000;
			dmin_q     <= 16'hFFFF;
			dmax_q     <= 16'h0000;
			rptr_q     <= '0;
			binned_q   <= '0;
			clr_q      <= '0;
			pix_q      <= '0;
			ph_q       <= ddh_pkg::PH_FETCH;
			cdone_q    <= 1'b0;
			rdone_q    <= 1'b0;
			bidx_q     <= '0;
			computed_q <= 1'b0;
			out_valid  <= 1'b0;
			ob_val_q   <= '0;
			ob_last_q  <= 1'b0;
			ob_stat_q  <= 1'b0;
			ob_bin_q   <= '0;
		end else begin
			out_valid <= out_load || (out_valid && out_stall);
			cdone_q   <= !div_go && (cdone_q || cdone);
			rdone_q   <= !div_go && (rdone_q || rdone);
			case (st_q)
				ddh_pkg::ST_IDLE: begin
					if (cmd_valid && cmd.op == ddh_pkg::OP_LOAD
					    && pcount_q < PC'(ddh_pkg::MaxPixels)) begin
						pcount_q <= pcount_q + PC'(1);
						if ($signed(cmd.vel) < vmin_q) vmin_q <= cmd.vel;
						if ($signed(cmd.vel) > vmax_q) vmax_q <= cmd.vel;
						if (cmd.dep > dmax_q) dmax_q <= cmd.dep;
						if (cmd.dep != 16'd0 && cmd.dep < dmin_q) dmin_q <= cmd.dep;
					end
					if (cmd_valid && cmd.op == ddh_pkg::OP_COMPUTE) begin
						clr_q    <= '0;
						pix_q    <= '0;
						ph_q     <= ddh_pkg::PH_FETCH;
						binned_q <= '0;
					end
				end
				ddh_pkg::ST_CLEAR: clr_q <= clr_q + BC'(1);
				ddh_pkg::ST_BIN: begin
					case (ph_q)
						ddh_pkg::PH_FETCH: if (pix_q != pcount_q) ph_q <= ddh_pkg::PH_START;
						ddh_pkg::PH_START: begin
							if (pix_ok) begin
								ph_q <= ddh_pkg::PH_WAIT;
							end else begin
								ph_q  <= ddh_pkg::PH_FETCH;
								pix_q <= pix_q + PC'(1);
							end
						end
						ddh_pkg::PH_WAIT: begin
							if (cdone_q && rdone_q) begin
								if (col_q >= w || row_q >= h) begin
									ph_q  <= ddh_pkg::PH_FETCH;
									pix_q <= pix_q + PC'(1);
								end else begin
									bidx_q <= BA'(BC'(row_q) * BC'(w) + BC'(col_q));
									ph_q   <= ddh_pkg::PH_RDBIN;
								end
							end
						end
						ddh_pkg::PH_RDBIN: ph_q <= ddh_pkg::PH_WRITE;
						ddh_pkg::PH_WRITE: begin
							ph_q  <= ddh_pkg::PH_FETCH;
							pix_q <= pix_q + PC'(1);
							if (binned_q != 17'h1FFFF) binned_q <= binned_q + 17'd1;
						end
						default: ph_q <= ddh_pkg::PH_FETCH;
					endcase
				end
				ddh_pkg::ST_STATUS: begin
					if (out_free) begin
						ob_val_q   <= '0;
						ob_last_q  <= 1'b0;
						ob_stat_q  <= 1'b1;
						ob_bin_q   <= binned_q;
						rptr_q     <= '0;
						computed_q <= 1'b1;
					end
				end
				ddh_pkg::ST_READ: begin
					if (rptr_q >= total) rptr_q <= '0;
				end
				ddh_pkg::ST_OUT: begin
					if (out_free) begin
						ob_val_q  <= computed_q ? img_rd_q : 32'd0;
						ob_last_q <= (rptr_q == total - BC'(1));
						ob_stat_q <= 1'b0;
						ob_bin_q  <= '0;
						rptr_q    <= (rptr_q == total - BC'(1)) ? '0 : rptr_q + BC'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign bin_value     = ob_val_q;
	assign bin_last      = ob_last_q;
	assign pixels_binned = ob_bin_q;
	assign is_status     = ob_stat_q;

endmodule
